/* design/sse_pkg.sv */
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types, sizes and font tables for the seven-segment string encoder.
// ----------------------------------------------------------------------------
package sse_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int MAX_CHARS  = 8;
    localparam int OUT_DIGITS = 4;
    localparam int SHOWN      = (NUM_DIGITS < OUT_DIGITS) ? NUM_DIGITS : OUT_DIGITS;
    localparam int FILL_W     = $clog2(NUM_DIGITS + 1);
    localparam int USED_W     = $clog2(MAX_CHARS + 1);
    localparam int CONS_W     = 4;

    localparam logic [7:0] SEG_BLANK      = 8'hFF;
    localparam logic [7:0] SEG_DASH       = 8'hBF;
    localparam logic [7:0] SEG_DP_MASK    = 8'h7F;
    localparam logic [7:0] SEG_UNDERSCORE = 8'hF7;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_TILDE      = 8'h7E;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;

    localparam logic [7:0] DIGIT_FONT [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h83, 8'hF8, 8'h80, 8'h98
    };

    localparam logic [7:0] LETTER_FONT [26] = '{
        8'h88, 8'h83, 8'hA7, 8'hA1, 8'h86, 8'h8E, 8'h90, 8'h89, 8'hF9, 8'hE1,
        8'h8F, 8'hC7, 8'hC8, 8'hAB, 8'hA3, 8'h8C, 8'h98, 8'hAF, 8'h92, 8'h87,
        8'hC1, 8'hE3, 8'hC1, 8'hC9, 8'h91, 8'hA4
    };

    typedef struct packed {
        logic [NUM_DIGITS-1:0][7:0] glyph;
        logic [FILL_W-1:0]          fill;
        logic                       prev_digit;
        logic [USED_W-1:0]          used;
        logic                       emitted;
    } t_state;

    typedef struct packed {
        logic [OUT_DIGITS-1:0][7:0] seg;
        logic [CONS_W-1:0]          consumed;
    } t_result;

    function automatic t_state reset_state();
        t_state s;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            s.glyph[i] = SEG_BLANK;
        end
        s.fill       = '0;
        s.prev_digit = 1'b0;
        s.used       = '0;
        s.emitted    = 1'b0;
        return s;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] glyph_of(input logic [7:0] c);
        logic [7:0] lo_off;
        logic [7:0] up_off;
        logic [7:0] dg_off;
        logic [7:0] g;
        lo_off = c - CH_LOWER_A;
        up_off = c - CH_UPPER_A;
        dg_off = c - CH_ZERO;
        if ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) begin
            g = LETTER_FONT[lo_off[4:0]];
        end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
            g = LETTER_FONT[up_off[4:0]];
        end else if (is_digit(c)) begin
            g = DIGIT_FONT[dg_off[3:0]];
        end else begin
            case (c)
                CH_DASH, CH_TILDE, CH_COLON: g = SEG_DASH;
                CH_UNDERSCORE:               g = SEG_UNDERSCORE;
                default:                     g = SEG_BLANK;
            endcase
        end
        return g;
    endfunction

endpackage

/* design/sse_step.sv */
// ----------------------------------------------------------------------------
// sse_step
// Next-state and result logic for one character of the string.
// ----------------------------------------------------------------------------
module sse_step (
    input  sse_pkg::t_state  i_state,
    input  logic [7:0]       i_ch,
    input  logic             i_last,
    output sse_pkg::t_state  o_state,
    output sse_pkg::t_result o_result,
    output logic             o_fire
);
    import sse_pkg::*;

    t_state w_upd;
    logic   w_fire;

    always_comb begin
        w_upd  = i_state;
        w_fire = 1'b0;
        if (!i_state.emitted) begin
            if (i_state.fill >= FILL_W'(NUM_DIGITS)) begin
                if (i_ch == CH_DOT) begin
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        if (i_state.fill == FILL_W'(i + 1)) begin
                            w_upd.glyph[i] = i_state.glyph[i] & SEG_DP_MASK;
                        end
                    end
                    w_upd.used = i_state.used + USED_W'(1);
                end
                w_fire = 1'b1;
            end else if (i_ch == CH_NUL) begin
                w_fire = 1'b1;
            end else if (i_state.prev_digit && (i_ch == CH_DOT)) begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    if (i_state.fill == FILL_W'(i + 1)) begin
                        w_upd.glyph[i] = i_state.glyph[i] & SEG_DP_MASK;
                    end
                end
                w_upd.prev_digit = 1'b0;
                w_upd.used       = i_state.used + USED_W'(1);
                if (w_upd.used >= USED_W'(MAX_CHARS)) begin
                    w_fire = 1'b1;
                end
            end else begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    if (i_state.fill == FILL_W'(i)) begin
                        w_upd.glyph[i] = glyph_of(i_ch);
                    end
                end
                w_upd.fill       = i_state.fill + FILL_W'(1);
                w_upd.prev_digit = is_digit(i_ch);
                w_upd.used       = i_state.used + USED_W'(1);
                if ((w_upd.used >= USED_W'(MAX_CHARS)) ||
                    ((w_upd.fill >= FILL_W'(NUM_DIGITS)) && !w_upd.prev_digit)) begin
                    w_fire = 1'b1;
                end
            end
            if (i_last) begin
                w_fire = 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < OUT_DIGITS; i++) begin
            o_result.seg[i] = SEG_BLANK;
        end
        for (int i = 0; i < SHOWN; i++) begin
            o_result.seg[i] = w_upd.glyph[i];
        end
        o_result.consumed = CONS_W'(w_upd.used);
    end

    always_comb begin
        if (i_last) begin
            o_state = reset_state();
        end else begin
            o_state = w_upd;
            if (w_fire) begin
                o_state.emitted = 1'b1;
            end
        end
    end

    assign o_fire = w_fire;

endmodule

/* design/seven_segment_string_encoder_core.sv */
// ----------------------------------------------------------------------------
// seven_segment_string_encoder_core
// Turns a character string into four active-low seven-segment bytes.
// ----------------------------------------------------------------------------
// One character is taken per word and every cycle can take a new one, unless
// the input register is full while a result waits and the receiver stalls. A
// word goes into an input register and is then folded into the display state
// by the font lookup and position update once the output register is free.
// One result word is given per string: when the display is full, eight
// characters are used, a NUL arrives or the last character is seen; the rest
// of the string up to its last word is then dropped. The output register lets
// a new character be taken while a result still waits to be taken.
// ----------------------------------------------------------------------------
module seven_segment_string_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_seg0,
    output logic [7:0] o_seg1,
    output logic [7:0] o_seg2,
    output logic [7:0] o_seg3,
    output logic [3:0] o_consumed
);
    import sse_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_last;
    t_state     r_st;
    t_state     n_st;
    t_result    r_res;
    t_result    n_res;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_fire;
    logic       w_out_free;
    logic       w_adv;
    logic       w_in_acc;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    sse_step u_step (
        .i_state (r_st),
        .i_ch    (r_ch),
        .i_last  (r_last),
        .o_state (n_st),
        .o_result(n_res),
        .o_fire  (w_fire)
    );

    assign n_out_valid = w_out_free ? (w_adv && w_fire) : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= reset_state();
        end else begin
            r_out_valid <= n_out_valid;
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
        if (w_adv && w_fire) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_seg0      = r_res.seg[0];
    assign o_seg1      = r_res.seg[1];
    assign o_seg2      = r_res.seg[2];
    assign o_seg3      = r_res.seg[3];
    assign o_consumed  = r_res.consumed;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.fill <= FILL_W'(NUM_DIGITS))
        else $error("fill position beyond display");

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.used <= USED_W'(MAX_CHARS))
        else $error("used count beyond limit");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_last) |=> (r_st.fill == '0) && (r_st.used == '0) && !r_st.emitted)
        else $error("state not cleared after last character");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_st.emitted) |-> !w_fire)
        else $error("second result for one string");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_fire) |=> o_out_valid)
        else $error("result lost");

endmodule

/* tb/segment_display_checker.sv */
// ----------------------------------------------------------------------------
// segment_display_checker
// Watches both channels of the seven-segment string encoder. Every accepted
// character is folded into a local copy of the display state, and each result
// word the block gives is compared field by field with the oldest predicted
// display word. The mismatch count and the number of display words still
// awaited are passed up to the test top.
// ----------------------------------------------------------------------------
module segment_display_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_seg0,
    input  logic [7:0] i_seg1,
    input  logic [7:0] i_seg2,
    input  logic [7:0] i_seg3,
    input  logic [3:0] i_consumed,
    output int         o_mismatches,
    output int         o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import sse_pkg::*;

    typedef struct packed {
        logic [7:0] seg0;
        logic [7:0] seg1;
        logic [7:0] seg2;
        logic [7:0] seg3;
        logic [3:0] consumed;
    } t_display_word;

    localparam logic [7:0] NUMERAL_SEGS [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h83, 8'hF8, 8'h80, 8'h98
    };

    localparam logic [7:0] ALPHA_SEGS [26] = '{
        8'h88, 8'h83, 8'hA7, 8'hA1, 8'h86, 8'h8E, 8'h90, 8'h89, 8'hF9, 8'hE1,
        8'h8F, 8'hC7, 8'hC8, 8'hAB, 8'hA3, 8'h8C, 8'h98, 8'hAF, 8'h92, 8'h87,
        8'hC1, 8'hE3, 8'hC1, 8'hC9, 8'h91, 8'hA4
    };

    t_display_word expected_displays[$];
    logic [7:0]    glyphs [NUM_DIGITS];
    int            fill_pos;
    bit            after_digit;
    int            chars_used;
    bit            string_done;
    int            mismatch_count = 0;
    int            awaited = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = awaited;

    function automatic bit is_numeral(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] font_glyph(input logic [7:0] c);
        if ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) return ALPHA_SEGS[int'(c - CH_LOWER_A)];
        if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) return ALPHA_SEGS[int'(c - CH_UPPER_A)];
        if (is_numeral(c)) return NUMERAL_SEGS[int'(c - CH_ZERO)];
        if ((c == CH_DASH) || (c == CH_TILDE) || (c == CH_COLON)) return SEG_DASH;
        if (c == CH_UNDERSCORE) return SEG_UNDERSCORE;
        return SEG_BLANK;
    endfunction

    function automatic logic [7:0] shown_glyph(input int pos);
        return (pos < NUM_DIGITS) ? glyphs[pos] : SEG_BLANK;
    endfunction

    task automatic clear_string();
        for (int i = 0; i < NUM_DIGITS; i++) begin
            glyphs[i] = SEG_BLANK;
        end
        fill_pos    = 0;
        after_digit = 1'b0;
        chars_used  = 0;
        string_done = 1'b0;
    endtask

    task automatic dot_onto_last();
        if ((fill_pos >= 1) && (fill_pos <= NUM_DIGITS)) begin
            glyphs[fill_pos-1] = glyphs[fill_pos-1] & SEG_DP_MASK;
        end
    endtask

    task automatic fold_char(input logic [7:0] c, input logic is_last);
        bit            fire;
        t_display_word w;
        fire = 1'b0;
        if (string_done) begin
            if (is_last) begin
                clear_string();
            end
            return;
        end
        if (fill_pos >= NUM_DIGITS) begin
            // display full after a digit: only a dot may still merge
            if (c == CH_DOT) begin
                dot_onto_last();
                chars_used++;
            end
            fire = 1'b1;
        end else if (c == CH_NUL) begin
            fire = 1'b1;
        end else if (after_digit && (c == CH_DOT)) begin
            dot_onto_last();
            after_digit = 1'b0;
            chars_used++;
            if (chars_used >= MAX_CHARS) begin
                fire = 1'b1;
            end
        end else begin
            glyphs[fill_pos] = font_glyph(c);
            fill_pos++;
            after_digit = is_numeral(c);
            chars_used++;
            if ((chars_used >= MAX_CHARS) || ((fill_pos >= NUM_DIGITS) && !after_digit)) begin
                fire = 1'b1;
            end
        end
        if (is_last) begin
            fire = 1'b1;
        end
        if (fire) begin
            w.seg0     = shown_glyph(0);
            w.seg1     = shown_glyph(1);
            w.seg2     = shown_glyph(2);
            w.seg3     = shown_glyph(3);
            w.consumed = 4'(chars_used);
            expected_displays.push_back(w);
        end
        if (is_last) begin
            clear_string();
        end else if (fire) begin
            string_done = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %h actual %h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_display_word want;
        if (!i_rst_n) begin
            clear_string();
            expected_displays.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_displays.size() == 0) begin
                    $error("unexpected word seg0 %h seg1 %h seg2 %h seg3 %h consumed %0d",
                           i_seg0, i_seg1, i_seg2, i_seg3, i_consumed);
                    mismatch_count++;
                end else begin
                    want = expected_displays.pop_front();
                    check_field("seg0", want.seg0, i_seg0);
                    check_field("seg1", want.seg1, i_seg1);
                    check_field("seg2", want.seg2, i_seg2);
                    check_field("seg3", want.seg3, i_seg3);
                    check_field("consumed", {4'b0, want.consumed}, {4'b0, i_consumed});
                end
            end
            if (i_in_valid && !i_in_stall) begin
                fold_char(i_ch, i_last);
            end
        end
        awaited = expected_displays.size();
    end

endmodule

/* tb/seven_segment_string_encoder_core_test.sv */
// ----------------------------------------------------------------------------
// seven_segment_string_encoder_core_test
// Drives strings into the seven-segment string encoder: a short directed set
// covering dots after digits, full displays, NUL and ignored tails, then
// random strings under several sender and receiver idle mixes and one long
// receiver hold-off. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module seven_segment_string_encoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sse_pkg::*;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam int         PHASE_WORDS = 125;
    localparam int         HOLD_CYCLES = 400;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_ch;
    logic       i_last;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_seg0;
    logic [7:0] o_seg1;
    logic [7:0] o_seg2;
    logic [7:0] o_seg3;
    logic [3:0] o_consumed;

    int mismatches;
    int outstanding;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit hold_request = 1'b0;
    int words_sent = 0;

    seven_segment_string_encoder_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_seg0      (o_seg0),
        .o_seg1      (o_seg1),
        .o_seg2      (o_seg2),
        .o_seg3      (o_seg3),
        .o_consumed  (o_consumed)
    );

    segment_display_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_ch          (i_ch),
        .i_last        (i_last),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_seg0        (o_seg0),
        .i_seg1        (o_seg1),
        .i_seg2        (o_seg2),
        .i_seg3        (o_seg3),
        .i_consumed    (o_consumed),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : receiver
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    task automatic send_word(input logic [7:0] c, input logic is_last);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        i_last     <= is_last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    task automatic send_text(input string s, input bit end_string);
        for (int i = 0; i < s.len(); i++) begin
            send_word(s[i], end_string && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 30) return CH_ZERO + 8'($urandom_range(9));
        if (r < 50) return CH_DOT;
        if (r < 58) return CH_UPPER_A + 8'($urandom_range(25));
        if (r < 66) return CH_LOWER_A + 8'($urandom_range(25));
        if (r < 76) begin
            case ($urandom_range(4))
                0:       return CH_DASH;
                1:       return CH_TILDE;
                2:       return CH_COLON;
                3:       return CH_UNDERSCORE;
                default: return SPACE_CHAR;
            endcase
        end
        if (r < 79) return CH_NUL;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_string();
        int len;
        bit noisy;
        len   = ($urandom_range(9) == 0) ? $urandom_range(16, 10) : $urandom_range(9, 1);
        noisy = ($urandom_range(9) == 0);
        for (int i = 0; i < len; i++) begin
            send_word(noisy ? 8'($urandom_range(255)) : pick_char(),
                      (i == len - 1) || (noisy && ($urandom_range(7) == 0)));
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        int target;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        target             = words_sent + count;
        while (words_sent < target) begin
            send_random_string();
        end
    endtask

    initial begin : stimulus
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_ch       = 8'h00;
        i_last     = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // dots after digits up to the character limit
        send_text("8.8.8.8.", 1'b1);
        // full after a letter, tail ignored
        send_text("aZ-_~", 1'b1);
        // leading dot takes a position, NUL ends the string
        send_text(".:9", 1'b0);
        send_word(CH_NUL, 1'b0);
        send_word("x", 1'b1);
        // full after a digit, next word is not a dot
        send_text("1234X", 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(CH_NUL, 1'b1);

        run_phase(0, 0, PHASE_WORDS);
        run_phase(55, 0, PHASE_WORDS);
        run_phase(0, 55, PHASE_WORDS);
        run_phase(24, 24, PHASE_WORDS);
        // long receiver hold-off while words keep coming
        hold_request = 1'b1;
        run_phase(0, 0, PHASE_WORDS);

        i_in_valid <= 1'b0;
        repeat (4) @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* seven_segment_string_encoder_core.f */
design/sse_pkg.sv
design/sse_step.sv
design/seven_segment_string_encoder_core.sv
tb/segment_display_checker.sv
tb/seven_segment_string_encoder_core_test.sv
